// ===== design/t1bfc_pkg.sv =====
// Shared types and constants for the T=1 block framer and checker.
package t1bfc_pkg;

	// Input item operation codes
	localparam logic [1:0] MODE_SEND_START = 2'd0;
	localparam logic [1:0] MODE_SEND_BYTE  = 2'd1;
	localparam logic [1:0] MODE_RECV_BYTE  = 2'd2;
	localparam logic [1:0] MODE_LINK_FAIL  = 2'd3;

	// Result kinds
	localparam logic [1:0] KIND_TX     = 2'd0;
	localparam logic [1:0] KIND_RX     = 2'd1;
	localparam logic [1:0] KIND_STATUS = 2'd2;

	// Receive status codes
	localparam logic [2:0] STAT_OK        = 3'd0;
	localparam logic [2:0] STAT_BAD_NAD   = 3'd4;
	localparam logic [2:0] STAT_LRC_ERR   = 3'd5;
	localparam logic [2:0] STAT_LINK_FAIL = 3'd6;

	// PCB decode for R-blocks
	localparam logic [7:0] PCB_TYPE_MASK = 8'hC0;
	localparam logic [7:0] PCB_R_BLOCK   = 8'h80;

	// Register indexes (byte address bit 2)
	localparam logic REG_SEND_NAD   = 1'b0;
	localparam logic REG_EXPECT_NAD = 1'b1;

	// Result queue sizing
	localparam int RES_MAX    = 4;
	localparam int FIFO_DEPTH = 8;
	localparam int FIFO_AW    = 3;

	typedef struct packed {
		logic [1:0] mode;
		logic [7:0] data_byte;
		logic [7:0] send_length;
	} in_item_t;

	typedef struct packed {
		logic [1:0] out_kind;
		logic [7:0] out_byte;
		logic [2:0] status_code;
		logic       last;
	} out_item_t;

	typedef struct packed {
		logic [2:0]            count;
		out_item_t [RES_MAX-1:0] item;
	} result_set_t;

endpackage

// ===== design/t1_block_framer_checker.sv =====
// Top level of the T=1 block framer and checker: config registers and result queue.
//
// Usage:
//   Input channel (in_valid/in_stall/in_item) takes one item per cycle unless
//   stalled: a send start with a payload length, a payload byte to send, a
//   byte received from the card, or a link failure. Output channel
//   (out_valid/out_stall/out_item) returns the results one per cycle unless
//   stalled: NAD, PCB, LEN, echoed payload and LRC for the transmit side;
//   streamed payload and one final status for the receive side. The last
//   result caused by an input item has last set. An item is worked in the
//   cycle it is accepted. Single-result items flow at one item per cycle
//   without stalls; a send start yields three or four results, so the
//   sustained rate is set by the one-result-per-cycle output port draining an
//   eight-entry queue. in_stall rises when fewer than four queue entries are
//   free. Reset clears the sequence bit, all framing state, both node address
//   registers and the queue. When the receiver stalls, the head result holds
//   and the queue fills; input is then stalled until room returns. Registers:
//   send NAD at byte address 0, expected NAD at byte address 4.
module t1_block_framer_checker (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  t1bfc_pkg::in_item_t  in_item,
	output logic                 out_valid,
	input  logic                 out_stall,
	output t1bfc_pkg::out_item_t out_item,
	input  logic                 psel,
	input  logic                 penable,
	input  logic                 pwrite,
	input  logic [2:0]           paddr,
	input  logic [31:0]          pwdata,
	output logic [31:0]          prdata,
	output logic                 pready
);
	import t1bfc_pkg::*;

	logic [7:0] send_nad_q;
	logic [7:0] expect_nad_q;

	logic        accept;
	logic        pop;
	result_set_t res;

	out_item_t          fifo_q [FIFO_DEPTH];
	logic [FIFO_AW-1:0] wr_ptr_q;
	logic [FIFO_AW-1:0] rd_ptr_q;
	logic [FIFO_AW:0]   count_q;
	logic [FIFO_AW:0]   push_cnt;

	// Config port: always ready, register picked by address bit 2
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			send_nad_q   <= '0;
			expect_nad_q <= '0;
		end else if (psel && penable && pwrite) begin
			if (paddr[2] == REG_EXPECT_NAD) begin
				expect_nad_q <= pwdata[7:0];
			end else begin
				send_nad_q <= pwdata[7:0];
			end
		end
	end

	assign prdata = (paddr[2] == REG_SEND_NAD) ? {24'd0, send_nad_q} : {24'd0, expect_nad_q};

	// Accept only while the queue can absorb the worst-case burst of results
	assign in_stall = (count_q > 4'(FIFO_DEPTH - RES_MAX));
	assign accept   = in_valid && !in_stall;

	t1bfc_engine u_engine (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (accept),
		.item       (in_item),
		.send_nad   (send_nad_q),
		.expect_nad (expect_nad_q),
		.res        (res)
	);

	// Result queue: head entry drives the output and holds while stalled
	assign out_valid = (count_q != '0);
	assign out_item  = fifo_q[rd_ptr_q];
	assign pop       = out_valid && !out_stall;
	assign push_cnt  = accept ? {1'b0, res.count} : '0;

	always_ff @(posedge clk) begin
		for (int i = 0; i < RES_MAX; i++) begin
			if (accept && (3'(i) < res.count)) begin
				fifo_q[wr_ptr_q + FIFO_AW'(i)] <= res.item[i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			// Advance write pointer by the burst, read pointer by one per pop
			wr_ptr_q <= wr_ptr_q + push_cnt[FIFO_AW-1:0];
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			count_q <= count_q + push_cnt - {{FIFO_AW{1'b0}}, pop};
		end
	end

endmodule

// ===== design/t1bfc_engine.sv =====
// Framing state and per-item result generation for transmit and receive.
module t1bfc_engine (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  accept,
	input  t1bfc_pkg::in_item_t   item,
	input  logic [7:0]            send_nad,
	input  logic [7:0]            expect_nad,
	output t1bfc_pkg::result_set_t res
);
	import t1bfc_pkg::*;

	logic       seq_q,       seq_n;
	logic [7:0] tx_rem_q,    tx_rem_n;
	logic [7:0] tx_par_q,    tx_par_n;
	logic [8:0] rx_pos_q,    rx_pos_n;
	logic [7:0] rx_len_q,    rx_len_n;
	logic [7:0] rx_par_q,    rx_par_n;
	logic [7:0] rx_pcb_q,    rx_pcb_n;
	logic       nad_bad_q,   nad_bad_n;

	logic [7:0] pcb;
	logic [7:0] par_upd;
	logic [8:0] rx_end;
	logic [2:0] final_code;

	assign pcb     = {1'b0, seq_q, 6'b0};
	assign par_upd = tx_par_q ^ item.data_byte;
	assign rx_end  = 9'd3 + {1'b0, rx_len_q};

	always_comb begin
		if (nad_bad_q) begin
			final_code = STAT_BAD_NAD;
		end else if (rx_par_q != item.data_byte) begin
			final_code = STAT_LRC_ERR;
		end else if ((rx_pcb_q & PCB_TYPE_MASK) == PCB_R_BLOCK) begin
			final_code = {1'b0, rx_pcb_q[1:0]};
		end else begin
			final_code = STAT_OK;
		end
	end

	always_comb begin
		seq_n     = seq_q;
		tx_rem_n  = tx_rem_q;
		tx_par_n  = tx_par_q;
		rx_pos_n  = rx_pos_q;
		rx_len_n  = rx_len_q;
		rx_par_n  = rx_par_q;
		rx_pcb_n  = rx_pcb_q;
		nad_bad_n = nad_bad_q;
		res       = '0;
		case (item.mode)
			MODE_SEND_START: begin
				seq_n    = ~seq_q;
				tx_par_n = send_nad ^ pcb ^ item.send_length;
				tx_rem_n = item.send_length;
				res.item[0] = '{KIND_TX, send_nad, STAT_OK, 1'b0};
				res.item[1] = '{KIND_TX, pcb, STAT_OK, 1'b0};
				if (item.send_length == 8'd0) begin
					res.item[2] = '{KIND_TX, item.send_length, STAT_OK, 1'b0};
					res.item[3] = '{KIND_TX, tx_par_n, STAT_OK, 1'b1};
					res.count   = 3'd4;
				end else begin
					res.item[2] = '{KIND_TX, item.send_length, STAT_OK, 1'b1};
					res.count   = 3'd3;
				end
			end
			MODE_SEND_BYTE: begin
				if (tx_rem_q != 8'd0) begin
					tx_par_n = par_upd;
					tx_rem_n = tx_rem_q - 8'd1;
					if (tx_rem_q == 8'd1) begin
						res.item[0] = '{KIND_TX, item.data_byte, STAT_OK, 1'b0};
						res.item[1] = '{KIND_TX, par_upd, STAT_OK, 1'b1};
						res.count   = 3'd2;
					end else begin
						res.item[0] = '{KIND_TX, item.data_byte, STAT_OK, 1'b1};
						res.count   = 3'd1;
					end
				end
			end
			MODE_RECV_BYTE: begin
				if (rx_pos_q == 9'd0) begin
					nad_bad_n = (item.data_byte != expect_nad);
					rx_par_n  = item.data_byte;
					rx_pos_n  = 9'd1;
				end else if (rx_pos_q == 9'd1) begin
					rx_pcb_n = item.data_byte;
					rx_par_n = rx_par_q ^ item.data_byte;
					rx_pos_n = 9'd2;
				end else if (rx_pos_q == 9'd2) begin
					rx_len_n = item.data_byte;
					rx_par_n = rx_par_q ^ item.data_byte;
					rx_pos_n = 9'd3;
				end else if (rx_pos_q < rx_end) begin
					rx_par_n    = rx_par_q ^ item.data_byte;
					rx_pos_n    = rx_pos_q + 9'd1;
					res.item[0] = '{KIND_RX, item.data_byte, STAT_OK, 1'b1};
					res.count   = 3'd1;
				end else begin
					rx_pos_n    = 9'd0;
					res.item[0] = '{KIND_STATUS, 8'd0, final_code, 1'b1};
					res.count   = 3'd1;
				end
			end
			default: begin
				seq_n       = ~seq_q;
				tx_rem_n    = 8'd0;
				rx_pos_n    = 9'd0;
				res.item[0] = '{KIND_STATUS, 8'd0, STAT_LINK_FAIL, 1'b1};
				res.count   = 3'd1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seq_q     <= 1'b0;
			tx_rem_q  <= '0;
			tx_par_q  <= '0;
			rx_pos_q  <= '0;
			rx_len_q  <= '0;
			rx_par_q  <= '0;
			rx_pcb_q  <= '0;
			nad_bad_q <= 1'b0;
		end else if (accept) begin
			seq_q     <= seq_n;
			tx_rem_q  <= tx_rem_n;
			tx_par_q  <= tx_par_n;
			rx_pos_q  <= rx_pos_n;
			rx_len_q  <= rx_len_n;
			rx_par_q  <= rx_par_n;
			rx_pcb_q  <= rx_pcb_n;
			nad_bad_q <= nad_bad_n;
		end
	end

endmodule

// ===== test/t1_block_framer_checker_mon.sv =====
// Framing checker: watches both channels and the register port, predicts and compares.
module t1_block_framer_checker_mon (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  logic                 in_stall,
	input  t1bfc_pkg::in_item_t  in_item,
	input  logic                 out_valid,
	input  logic                 out_stall,
	input  t1bfc_pkg::out_item_t out_item,
	input  logic                 psel,
	input  logic                 penable,
	input  logic                 pwrite,
	input  logic                 pready,
	input  logic [2:0]           paddr,
	input  logic [31:0]          pwdata,
	output int                   fail_count,
	output int                   pending_count
);
	import t1bfc_pkg::*;

	// Register copies
	logic [7:0] tx_nad;
	logic [7:0] rx_nad;

	// Framing state
	logic       seq_bit;
	logic [7:0] tx_left;
	logic [7:0] tx_lrc;
	logic [8:0] rx_pos;
	logic [7:0] rx_len;
	logic [7:0] rx_lrc;
	logic [7:0] rx_pcb;
	logic       nad_bad;

	out_item_t frame_results[$];

	initial fail_count = 0;

	task automatic report_mismatch(input string msg);
		$display("%0t framing mismatch: %s", $time, msg);
		fail_count++;
	endtask

	task automatic expect_result(input logic [1:0] kind, input logic [7:0] data_val,
			input logic [2:0] code, input logic fin);
		out_item_t r;
		r.out_kind = kind;
		r.out_byte = data_val;
		r.status_code = code;
		r.last = fin;
		frame_results.push_back(r);
	endtask

	task automatic frame_item(input in_item_t it);
		logic [7:0] pcb;
		logic [2:0] code;
		case (it.mode)
			MODE_SEND_START: begin
				pcb = {1'b0, seq_bit, 6'd0};
				seq_bit = ~seq_bit;
				tx_lrc = tx_nad ^ pcb ^ it.send_length;
				tx_left = it.send_length;
				expect_result(KIND_TX, tx_nad, STAT_OK, 1'b0);
				expect_result(KIND_TX, pcb, STAT_OK, 1'b0);
				if (it.send_length == 8'd0) begin
					expect_result(KIND_TX, it.send_length, STAT_OK, 1'b0);
					expect_result(KIND_TX, tx_lrc, STAT_OK, 1'b1);
				end else begin
					expect_result(KIND_TX, it.send_length, STAT_OK, 1'b1);
				end
			end
			MODE_SEND_BYTE: begin
				if (tx_left != 8'd0) begin
					tx_lrc = tx_lrc ^ it.data_byte;
					tx_left = tx_left - 8'd1;
					if (tx_left == 8'd0) begin
						expect_result(KIND_TX, it.data_byte, STAT_OK, 1'b0);
						expect_result(KIND_TX, tx_lrc, STAT_OK, 1'b1);
					end else begin
						expect_result(KIND_TX, it.data_byte, STAT_OK, 1'b1);
					end
				end
			end
			MODE_RECV_BYTE: begin
				if (rx_pos == 9'd0) begin
					nad_bad = (it.data_byte != rx_nad);
					rx_lrc = it.data_byte;
					rx_pos = 9'd1;
				end else if (rx_pos == 9'd1) begin
					rx_pcb = it.data_byte;
					rx_lrc = rx_lrc ^ it.data_byte;
					rx_pos = 9'd2;
				end else if (rx_pos == 9'd2) begin
					rx_len = it.data_byte;
					rx_lrc = rx_lrc ^ it.data_byte;
					rx_pos = 9'd3;
				end else if (rx_pos < {1'b0, rx_len} + 9'd3) begin
					rx_lrc = rx_lrc ^ it.data_byte;
					rx_pos = rx_pos + 9'd1;
					expect_result(KIND_RX, it.data_byte, STAT_OK, 1'b1);
				end else begin
					// status priority: address, then LRC, then R-block code
					if (nad_bad)
						code = STAT_BAD_NAD;
					else if (rx_lrc != it.data_byte)
						code = STAT_LRC_ERR;
					else if ((rx_pcb & PCB_TYPE_MASK) == PCB_R_BLOCK)
						code = {1'b0, rx_pcb[1:0]};
					else
						code = STAT_OK;
					rx_pos = 9'd0;
					expect_result(KIND_STATUS, 8'd0, code, 1'b1);
				end
			end
			default: begin
				seq_bit = ~seq_bit;
				tx_left = 8'd0;
				rx_pos = 9'd0;
				expect_result(KIND_STATUS, 8'd0, STAT_LINK_FAIL, 1'b1);
			end
		endcase
	endtask

	task automatic check_result(input out_item_t got);
		out_item_t want;
		if (frame_results.size() == 0) begin
			report_mismatch($sformatf("unexpected result kind %0d byte %02h status %0d last %0b",
				got.out_kind, got.out_byte, got.status_code, got.last));
			return;
		end
		want = frame_results.pop_front();
		if (got.out_kind !== want.out_kind || got.out_byte !== want.out_byte ||
				got.status_code !== want.status_code || got.last !== want.last)
			report_mismatch($sformatf(
				"kind %0d/%0d byte %02h/%02h status %0d/%0d last %0b/%0b (got/want)",
				got.out_kind, want.out_kind, got.out_byte, want.out_byte,
				got.status_code, want.status_code, got.last, want.last));
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tx_nad = 8'd0;
			rx_nad = 8'd0;
			seq_bit = 1'b0;
			tx_left = 8'd0;
			tx_lrc = 8'd0;
			rx_pos = 9'd0;
			rx_len = 8'd0;
			rx_lrc = 8'd0;
			rx_pcb = 8'd0;
			nad_bad = 1'b0;
			frame_results.delete();
			pending_count = 0;
		end else begin
			if (psel && penable && pwrite && pready) begin
				if (paddr[2] == REG_EXPECT_NAD)
					rx_nad = pwdata[7:0];
				else
					tx_nad = pwdata[7:0];
			end
			// results of an item are queued before they reach the output, so compare before predicting
			if (out_valid && !out_stall)
				check_result(out_item);
			if (in_valid && !in_stall)
				frame_item(in_item);
			pending_count = frame_results.size();
		end
	end

endmodule

// ===== test/t1_block_framer_checker_tb.sv =====
// Testbench top for the T=1 block framer and checker: stimulus, idling and verdict.
module t1_block_framer_checker_tb;
	import t1bfc_pkg::*;

	localparam int CYCLE_LIMIT = 300000;
	localparam int HOLD_CYCLES = 80;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	in_item_t    in_item = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	out_item_t   out_item;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [2:0]  paddr = 3'd0;
	logic [31:0] pwdata = 32'd0;
	logic [31:0] prdata;
	logic        pready;

	int fail_count;
	int pending_count;
	int cycle_count = 0;
	int item_count = 0;

	// idling control shared between sender and receiver
	bit no_idle = 1'b0;
	bit hold_off_req = 1'b0;

	// NAD the block currently expects, so received frames can be made to match
	logic [7:0] cur_rx_nad = 8'd0;

	t1_block_framer_checker dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_item  (in_item),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_item (out_item),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	t1_block_framer_checker_mon framing_check (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.in_item      (in_item),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.out_item     (out_item),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.pready       (pready),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.fail_count   (fail_count),
		.pending_count(pending_count)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Give up if the run stalls somewhere.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("t1_block_framer_checker_tb: done, errors");
			$finish;
		end
	end

	// Receiver: stall in random bursts, or hold off for a long stretch on request
	// so the result queue fills and the block backs up its input.
	initial begin
		forever begin
			@(posedge clk);
			if (hold_off_req) begin
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_off_req = 1'b0;
				out_stall <= 1'b0;
			end else if (!no_idle && $urandom_range(0, 5) == 0) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 10)) @(posedge clk);
				out_stall <= 1'b0;
			end
		end
	end

	function automatic in_item_t make_item(input logic [1:0] mode, input logic [7:0] data_val,
			input logic [7:0] len);
		in_item_t it;
		it.mode = mode;
		it.data_byte = data_val;
		it.send_length = len;
		return it;
	endfunction

	// Offer one item, maybe after a random gap, and hold it until accepted.
	task automatic push_item(input in_item_t it);
		if (!no_idle && $urandom_range(0, 5) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 10)) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_item <= it;
		do
			@(posedge clk);
		while (in_stall !== 1'b0);
		item_count++;
	endtask

	task automatic cfg_write(input logic idx, input logic [7:0] val);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= {24'd0, val};
		@(posedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (pready !== 1'b1);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (idx == REG_EXPECT_NAD)
			cur_rx_nad = val;
	endtask

	// Drop valid, let every expected result come out, then cover the latency of
	// items that give no result before touching the registers.
	task automatic drain;
		in_valid <= 1'b0;
		repeat (2) @(posedge clk);
		wait (pending_count == 0);
		repeat (4) @(posedge clk);
	endtask

	// Start a send frame of len bytes and push sent payload bytes; fewer than len
	// leaves the frame open, more than len adds stray bytes.
	task automatic send_frame(input logic [7:0] len, input int sent);
		int i;
		push_item(make_item(MODE_SEND_START, 8'($urandom), len));
		for (i = 0; i < sent; i++)
			push_item(make_item(MODE_SEND_BYTE, 8'($urandom), 8'($urandom)));
	endtask

	// Feed a card block byte by byte; cut below len aborts it with a link failure.
	task automatic recv_frame(input logic [7:0] nad, input logic [7:0] pcb,
			input logic [7:0] len, input bit good_lrc, input int cut);
		logic [7:0] lrc;
		logic [7:0] data_val;
		int i;
		lrc = nad ^ pcb ^ len;
		push_item(make_item(MODE_RECV_BYTE, nad, 8'($urandom)));
		push_item(make_item(MODE_RECV_BYTE, pcb, 8'($urandom)));
		push_item(make_item(MODE_RECV_BYTE, len, 8'($urandom)));
		for (i = 0; i < len; i++) begin
			if (i == cut) begin
				push_item(make_item(MODE_LINK_FAIL, 8'($urandom), 8'($urandom)));
				return;
			end
			data_val = 8'($urandom);
			lrc = lrc ^ data_val;
			push_item(make_item(MODE_RECV_BYTE, data_val, 8'($urandom)));
		end
		if (!good_lrc)
			lrc = lrc ^ 8'($urandom_range(1, 255));
		push_item(make_item(MODE_RECV_BYTE, lrc, 8'($urandom)));
	endtask

	// Mostly well-formed send and receive blocks with random content, the rest noise.
	task automatic random_phase(input int n_items);
		int stop_at;
		int pick;
		int sent;
		int cut;
		logic [7:0] len;
		logic [7:0] nad;
		logic [7:0] pcb;
		stop_at = item_count + n_items;
		while (item_count < stop_at) begin
			pick = $urandom_range(0, 9);
			if ($urandom_range(0, 9) == 0)
				len = 8'($urandom_range(7, 30));
			else
				len = 8'($urandom_range(0, 6));
			if (pick < 4) begin
				sent = len;
				if ($urandom_range(0, 5) == 0)
					sent = $urandom_range(0, len + 2);
				send_frame(len, sent);
			end else if (pick < 8) begin
				nad = cur_rx_nad;
				if ($urandom_range(0, 7) == 0)
					nad = 8'($urandom);
				case ($urandom_range(0, 2))
					0: pcb = {2'b10, 6'($urandom)};
					1: pcb = {1'b0, 7'($urandom)};
					default: pcb = {2'b11, 6'($urandom)};
				endcase
				cut = len;
				if (len != 8'd0 && $urandom_range(0, 9) == 0)
					cut = $urandom_range(0, len - 1);
				recv_frame(nad, pcb, len, $urandom_range(0, 5) != 0, cut);
			end else begin
				push_item(make_item(2'($urandom), 8'($urandom), 8'($urandom)));
			end
		end
	endtask

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		cfg_write(REG_SEND_NAD, 8'hA5);
		cfg_write(REG_EXPECT_NAD, 8'h3C);

		// Zero-length send gives all four prologue/epilogue bytes at once; the
		// byte after it has nothing owed and is dropped.
		send_frame(8'd0, 1);
		send_frame(8'd2, 2);
		// Length 255 frame, abandoned by a restart.
		send_frame(8'd255, 0);
		send_frame(8'd1, 1);
		push_item(make_item(MODE_LINK_FAIL, 8'hFF, 8'hFF));
		// An R-block code, bad address, LRC mismatch, and a link failure mid-block.
		recv_frame(8'h3C, 8'h83, 8'd0, 1'b1, 0);
		recv_frame(8'h00, 8'h81, 8'd0, 1'b1, 0);
		recv_frame(8'h3C, 8'h40, 8'd0, 1'b0, 0);
		recv_frame(8'h3C, 8'h82, 8'd2, 1'b1, 1);
		drain();

		// Low extremes; hold off the receiver while items keep coming.
		cfg_write(REG_SEND_NAD, 8'h00);
		cfg_write(REG_EXPECT_NAD, 8'h00);
		hold_off_req = 1'b1;
		random_phase(110);
		drain();

		// High extremes; a received block with LEN 255 is cut short.
		cfg_write(REG_SEND_NAD, 8'hFF);
		cfg_write(REG_EXPECT_NAD, 8'hFF);
		recv_frame(cur_rx_nad, 8'h00, 8'd255, 1'b1, 20);
		random_phase(80);
		drain();

		// Random addresses; finish with no idling at all.
		cfg_write(REG_SEND_NAD, 8'($urandom));
		cfg_write(REG_EXPECT_NAD, 8'($urandom));
		random_phase(80);
		no_idle = 1'b1;
		random_phase(45);
		drain();
		repeat (10) @(posedge clk);

		if (fail_count == 0 && pending_count == 0)
			$display("t1_block_framer_checker_tb: done, clean");
		else
			$display("t1_block_framer_checker_tb: done, errors");
		$finish;
	end

endmodule

// ===== sim.f =====
design/t1bfc_pkg.sv
design/t1bfc_engine.sv
design/t1_block_framer_checker.sv
test/t1_block_framer_checker_mon.sv
test/t1_block_framer_checker_tb.sv
